// File: sv/vol_header_field_parser_top_defines.svh
// Assertion macros shared by the parser modules.
// Each expects clk and arst_n in scope of the module that uses it.
`ifndef VOL_HEADER_FIELD_PARSER_TOP_DEFINES_SVH
`define VOL_HEADER_FIELD_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VHFP_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) prop) else $error(msg);
`define VHFP_NEVER(lbl, expr, msg) `VHFP_ASSERT(lbl, !(expr), msg)
`else
`define VHFP_ASSERT(lbl, prop, msg)
`define VHFP_NEVER(lbl, expr, msg)
`endif

`endif

// File: sv/vhfp_pkg.sv
package vhfp_pkg;

	localparam int DIM_BITS   = 13;
	localparam int FIFO_DEPTH = 4;

	localparam int ACC_W   = 16;
	localparam int LEFT_W  = 6;
	localparam int TBITS_W = 5;

	localparam logic [3:0] ASPECT_EXT = 4'hF;
	localparam logic [1:0] SHAPE_RECT = 2'd0;
	localparam logic [1:0] SHAPE_GRAY = 2'd3;
	localparam logic [3:0] VER_ONE    = 4'd1;

	typedef enum logic [5:0] {
		F_START, F_RAND, F_OTYPE, F_ISID, F_VERID, F_PRIO, F_ASPECT, F_PARW,
		F_PARH, F_CTRL, F_CHROMA, F_LOWD, F_VBVF,
		F_V0, F_V1, F_V2, F_V3, F_V4, F_V5, F_V6, F_V7, F_V8, F_V9, F_V10,
		F_SHAPE, F_SHAPEEXT, F_MARK1, F_TICKS, F_MARK2, F_FIXED, F_DUR,
		F_MARKW, F_WIDTH, F_MARKH, F_HEIGHT, F_MARKE, F_DONE
	} vhfp_step_t;

	// one header byte as it travels from the front queue to the parser
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} vhfp_beat_t;

	// bit length of each fixed-size field; duration and dimensions are sized elsewhere
	function automatic logic [LEFT_W-1:0] fld_len(vhfp_step_t s);
		logic [LEFT_W-1:0] n;
		unique case (s)
			F_START:                      n = 6'd32;
			F_OTYPE, F_PARW, F_PARH:      n = 6'd8;
			F_VERID, F_ASPECT, F_SHAPEEXT: n = 6'd4;
			F_PRIO, F_V6:                 n = 6'd3;
			F_CHROMA, F_SHAPE:            n = 6'd2;
			F_V0, F_V2, F_V4, F_V9:       n = 6'd15;
			F_V7:                         n = 6'd11;
			F_TICKS:                      n = 6'd16;
			F_DUR, F_DONE:                n = 6'd0;
			default:                      n = 6'd1;
		endcase
		return n;
	endfunction

endpackage

// File: sv/vhfp_front.sv
module vhfp_front #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  vhfp_pkg::vhfp_beat_t in_beat,
	output logic               beat_valid,
	output vhfp_pkg::vhfp_beat_t beat,
	input  logic               beat_take
);
	import vhfp_pkg::*;

	`include "vol_header_field_parser_top_defines.svh"

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	vhfp_beat_t      mem_q [FIFO_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            wr_en;
	logic            rd_en;

	assign full       = (cnt_q == CW'(FIFO_DEPTH));
	assign beat_valid = (cnt_q != '0);
	assign beat       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = beat_take && beat_valid;

	// store accepted beats
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= in_beat;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`VHFP_NEVER(a_cnt_bound, cnt_q > CW'(FIFO_DEPTH), "front queue count overflow")
	`VHFP_ASSERT(a_cnt_up, wr_en && !rd_en |=> cnt_q == $past(cnt_q) + CW'(1), "count missed a push")
	`VHFP_ASSERT(a_cnt_dn, rd_en && !wr_en |=> cnt_q == $past(cnt_q) - CW'(1), "count missed a take")

endmodule

// File: sv/vhfp_parser.sv
module vhfp_parser #(
	parameter int DIM_BITS = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_valid,
	input  vhfp_pkg::vhfp_beat_t beat,
	output logic                 beat_take,
	output logic                 empty,
	input  logic                 pop,
	output logic                 parse_ok,
	output logic [4:0]           time_bits,
	output logic [15:0]          time_ticks,
	output logic [15:0]          frame_duration,
	output logic [DIM_BITS-1:0]  frame_width,
	output logic [DIM_BITS-1:0]  frame_height
);
	import vhfp_pkg::*;

	`include "vol_header_field_parser_top_defines.svh"

	// current byte
	logic               busy_q;
	logic [7:0]         byte_q;
	logic               last_q;
	logic [2:0]         bitcnt_q;

	// parse state
	vhfp_step_t         step_q, step_n, nxt;
	logic [LEFT_W-1:0]  left_q, left_n, left_dec;
	logic [ACC_W-1:0]   acc_q, acc_n, acc_sh;
	logic [3:0]         ver_q, ver_n;
	logic [1:0]         shape_q, shape_n;
	logic [15:0]        ticks_q, ticks_n;
	logic [TBITS_W-1:0] bits_q, bits_n;
	logic [15:0]        dur_q, dur_n;
	logic [DIM_BITS-1:0] wid_q, wid_n;
	logic [DIM_BITS-1:0] hgt_q, hgt_n;
	logic               fin_q, fin_n;

	// parse state before the end-of-header clear
	vhfp_step_t         p_step;
	logic [LEFT_W-1:0]  p_left;
	logic [ACC_W-1:0]   p_acc;
	logic [3:0]         p_ver;
	logic [1:0]         p_shape;
	logic [15:0]        p_ticks;
	logic [TBITS_W-1:0] p_bits;
	logic [15:0]        p_dur;
	logic [DIM_BITS-1:0] p_wid;
	logic [DIM_BITS-1:0] p_hgt;
	logic               p_fin;

	// result register
	logic               ov_q;
	logic               o_ok_q;
	logic [4:0]         o_bits_q;
	logic [15:0]        o_ticks_q;
	logic [15:0]        o_dur_q;
	logic [DIM_BITS-1:0] o_wid_q;
	logic [DIM_BITS-1:0] o_hgt_q;

	logic bit_w, field_end, jump;
	logic finish_now, fail_now, byte_end, emit_req, can_emit, adv, hdr_end;

	assign bit_w    = byte_q[7];
	assign acc_sh   = {acc_q[ACC_W-2:0], bit_w};
	assign left_dec = left_q - LEFT_W'(1);
	assign field_end = (left_dec == '0);

	// walk one bit through the field sequence
	always_comb begin
		p_step  = step_q;
		p_left  = left_q;
		p_acc   = acc_q;
		p_ver   = ver_q;
		p_shape = shape_q;
		p_ticks = ticks_q;
		p_bits  = bits_q;
		p_dur   = dur_q;
		p_wid   = wid_q;
		p_hgt   = hgt_q;
		p_fin   = fin_q;
		nxt     = step_q;
		jump    = 1'b0;
		if (!fin_q) begin
			p_acc  = acc_sh;
			p_left = left_dec;
			// bit length grows once the first one bit has gone by
			if (step_q == F_TICKS) begin
				p_bits = (bits_q != '0 || bit_w) ? bits_q + TBITS_W'(1) : '0;
			end
			if (field_end) begin
				jump = 1'b1;
				unique case (step_q)
					F_ISID:   nxt = (acc_sh != '0) ? F_VERID : F_ASPECT;
					F_VERID: begin
						p_ver = acc_sh[3:0];
						nxt   = F_PRIO;
					end
					F_ASPECT: nxt = (acc_sh[3:0] == ASPECT_EXT) ? F_PARW : F_CTRL;
					F_CTRL:   nxt = (acc_sh != '0) ? F_CHROMA : F_SHAPE;
					F_VBVF:   nxt = (acc_sh != '0) ? F_V0 : F_SHAPE;
					F_V10:    nxt = F_SHAPE;
					F_SHAPE: begin
						p_shape = acc_sh[1:0];
						nxt = (acc_sh[1:0] == SHAPE_GRAY && ver_q != VER_ONE) ?
							F_SHAPEEXT : F_MARK1;
					end
					F_TICKS: begin
						p_ticks = acc_sh;
						nxt     = F_MARK2;
					end
					F_FIXED: begin
						if (acc_sh != '0 && bits_q != '0) begin
							nxt = F_DUR;
						end else begin
							p_dur = '0;
							nxt   = (shape_q == SHAPE_RECT) ? F_MARKW : F_DONE;
						end
					end
					F_DUR: begin
						p_dur = acc_sh;
						nxt   = (shape_q == SHAPE_RECT) ? F_MARKW : F_DONE;
					end
					F_WIDTH: begin
						p_wid = acc_sh[DIM_BITS-1:0];
						nxt   = F_MARKH;
					end
					F_HEIGHT: begin
						p_hgt = acc_sh[DIM_BITS-1:0];
						nxt   = F_MARKE;
					end
					F_MARKE:  nxt = F_DONE;
					F_DONE:   nxt = F_DONE;
					default:  nxt = vhfp_step_t'(step_q + 6'd1);
				endcase
			end
			// open the next field
			if (jump) begin
				p_step = nxt;
				p_acc  = '0;
				p_fin  = (nxt == F_DONE);
				if (nxt == F_DUR) begin
					p_left = LEFT_W'(p_bits);
				end else if (nxt == F_WIDTH || nxt == F_HEIGHT) begin
					p_left = LEFT_W'(DIM_BITS);
				end else begin
					p_left = fld_len(nxt);
				end
			end
		end
	end

	assign finish_now = busy_q && !fin_q && p_fin;
	assign byte_end   = fin_q || (bitcnt_q == 3'd7) || finish_now;
	assign fail_now   = busy_q && !fin_q && !p_fin && last_q && (bitcnt_q == 3'd7);
	assign emit_req   = finish_now || fail_now;
	assign can_emit   = !ov_q || pop;
	assign adv        = busy_q && (!emit_req || can_emit);
	assign hdr_end    = last_q && byte_end;
	assign beat_take  = beat_valid && (!busy_q || (adv && byte_end));

	// clear everything after the final byte of a header
	always_comb begin
		if (hdr_end) begin
			step_n  = F_START;
			left_n  = fld_len(F_START);
			acc_n   = '0;
			ver_n   = '0;
			shape_n = '0;
			ticks_n = '0;
			bits_n  = '0;
			dur_n   = '0;
			wid_n   = '0;
			hgt_n   = '0;
			fin_n   = 1'b0;
		end else begin
			step_n  = p_step;
			left_n  = p_left;
			acc_n   = p_acc;
			ver_n   = p_ver;
			shape_n = p_shape;
			ticks_n = p_ticks;
			bits_n  = p_bits;
			dur_n   = p_dur;
			wid_n   = p_wid;
			hgt_n   = p_hgt;
			fin_n   = p_fin;
		end
	end

	// hold the current byte and shift out one bit a cycle while the parser advances
	always_ff @(posedge clk) begin
		if (beat_take) begin
			byte_q <= beat.data;
			last_q <= beat.last;
		end else if (adv) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			bitcnt_q <= '0;
			step_q   <= F_START;
			left_q   <= fld_len(F_START);
			acc_q    <= '0;
			ver_q    <= '0;
			shape_q  <= '0;
			ticks_q  <= '0;
			bits_q   <= '0;
			dur_q    <= '0;
			wid_q    <= '0;
			hgt_q    <= '0;
			fin_q    <= 1'b0;
		end else begin
			if (beat_take) begin
				busy_q   <= 1'b1;
				bitcnt_q <= '0;
			end else if (adv) begin
				busy_q   <= !byte_end;
				bitcnt_q <= bitcnt_q + 3'd1;
			end
			if (adv) begin
				step_q  <= step_n;
				left_q  <= left_n;
				acc_q   <= acc_n;
				ver_q   <= ver_n;
				shape_q <= shape_n;
				ticks_q <= ticks_n;
				bits_q  <= bits_n;
				dur_q   <= dur_n;
				wid_q   <= wid_n;
				hgt_q   <= hgt_n;
				fin_q   <= fin_n;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_req && adv) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	// capture the result beat
	always_ff @(posedge clk) begin
		if (emit_req && adv) begin
			o_ok_q    <= finish_now;
			o_bits_q  <= finish_now ? p_bits  : '0;
			o_ticks_q <= finish_now ? p_ticks : '0;
			o_dur_q   <= finish_now ? p_dur   : '0;
			o_wid_q   <= finish_now ? p_wid   : '0;
			o_hgt_q   <= finish_now ? p_hgt   : '0;
		end
	end

	assign empty          = !ov_q;
	assign parse_ok       = o_ok_q;
	assign time_bits      = o_bits_q;
	assign time_ticks     = o_ticks_q;
	assign frame_duration = o_dur_q;
	assign frame_width    = o_wid_q;
	assign frame_height   = o_hgt_q;

	`VHFP_NEVER(a_emit_full, emit_req && adv && ov_q && !pop, "result beat overwritten")
	`VHFP_ASSERT(a_fin_done, fin_q |-> step_q == F_DONE, "finished outside done step")
	`VHFP_ASSERT(a_fail_zero, ov_q && !o_ok_q |-> o_ticks_q == '0 && o_bits_q == '0,
		"failure beat carries data")

endmodule

// File: sv/vol_header_field_parser_top.sv
// Channel   Handshake        Payload
// input     push / full      header_byte[7:0], last_byte
// result    empty / pop      parse_ok, time_bits, time_ticks, frame_duration,
//                            frame_width, frame_height
//
// The parser consumes one header bit per cycle when not stalled: a byte is walked
// bit by bit while a header is being parsed, the completing byte stops at its last
// field bit, and a later byte is dropped. A queue of FIFO_DEPTH bytes takes beats.
// One result register holds a finished beat; the parser stalls only on a cycle
// that must write a result while that register is still occupied and not popped.
// arst_n clears the queue, the parser state and the result register at once.
module vol_header_field_parser_top #(
	parameter int DIM_BITS   = vhfp_pkg::DIM_BITS,
	parameter int FIFO_DEPTH = vhfp_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          header_byte,
	input  logic                last_byte,
	output logic                empty,
	input  logic                pop,
	output logic                parse_ok,
	output logic [4:0]          time_bits,
	output logic [15:0]         time_ticks,
	output logic [15:0]         frame_duration,
	output logic [DIM_BITS-1:0] frame_width,
	output logic [DIM_BITS-1:0] frame_height
);
	import vhfp_pkg::*;

	vhfp_beat_t in_beat;
	vhfp_beat_t beat;
	logic       beat_valid;
	logic       beat_take;

	assign in_beat.data = header_byte;
	assign in_beat.last = last_byte;

	vhfp_front #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_beat   (in_beat),
		.beat_valid(beat_valid),
		.beat      (beat),
		.beat_take (beat_take)
	);

	vhfp_parser #(
		.DIM_BITS(DIM_BITS)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_valid    (beat_valid),
		.beat          (beat),
		.beat_take     (beat_take),
		.empty         (empty),
		.pop           (pop),
		.parse_ok      (parse_ok),
		.time_bits     (time_bits),
		.time_ticks    (time_ticks),
		.frame_duration(frame_duration),
		.frame_width   (frame_width),
		.frame_height  (frame_height)
	);

endmodule
